// ===== sv/ssm_pkg.sv =====
// Shared types, register codes and helpers of the stereo sound mixer.
// No dependencies; used by ssm_side and stereo_sound_mixer_top.
`default_nettype none

package ssm_pkg;

	localparam int unsigned InWidth    = 36;
	localparam int unsigned InBytes    = 40;
	localparam int unsigned OutWidth   = 15;
	localparam int unsigned OutBytes   = 32;
	localparam int unsigned AddrWidth  = 5;
	localparam logic [8:0]  BiasReset  = 9'h100;

	typedef enum logic [2:0] {
		REG_PSG_MASTER_LEFT  = 3'd0,
		REG_PSG_MASTER_RIGHT = 3'd1,
		REG_PSG_ROUTE        = 3'd2,
		REG_PSG_RATIO_CODE   = 3'd3,
		REG_DMA_FULL_MASK    = 3'd4,
		REG_DMA_ROUTE        = 3'd5,
		REG_BIAS_LEVEL       = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		RATIO_QUARTER = 2'd0,
		RATIO_HALF    = 2'd1,
		RATIO_FULL    = 2'd2,
		RATIO_FULL_ALT = 2'd3
	} ratio_t;

	// First field in the lowest bits: packed structs list the MSB member first.
	typedef struct packed {
		logic signed [7:0] dma_b_sample;
		logic signed [7:0] dma_a_sample;
		logic signed [4:0] psg4_level;
		logic signed [4:0] psg3_level;
		logic signed [4:0] psg2_level;
		logic signed [4:0] psg1_level;
	} item_t;

	typedef struct packed {
		logic [3:0] tone_en;
		logic [1:0] dma_en;
		logic [2:0] master;
		logic [1:0] dma_full;
		logic [1:0] ratio;
		logic [8:0] bias;
	} side_cfg_t;

	function automatic logic [1:0] ratio_shift(input logic [1:0] code);
		logic [1:0] sh;
		unique case (ratio_t'(code))
			RATIO_QUARTER:  sh = 2'd2;
			RATIO_HALF:     sh = 2'd1;
			RATIO_FULL:     sh = 2'd0;
			RATIO_FULL_ALT: sh = 2'd0;
			default:        sh = 2'd0;
		endcase
		return sh;
	endfunction

endpackage

`default_nettype wire

// ===== sv/stereo_sound_mixer_top.sv =====
// Stereo sound mixer: input register, two side mixers, output register.
// An accepted item passes the input register, then the output register; 1 item/cycle while results are taken.
// The output register decouples the sides, so input flows while a result waits
// unless both stages are full and the result is stalled.
// arst_n clears valid flags and config (bias_level to 256, others to 0).
// Depends on ssm_pkg and ssm_side.
`default_nettype none

module stereo_sound_mixer_top
	import ssm_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	// APB configuration
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire [AddrWidth-1:0]  paddr,
	input  wire [31:0]           pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// input stream
	input  wire                  s_axis_tvalid,
	output logic                 s_axis_tready,
	// psg1_level[4:0], psg2_level[9:5], psg3_level[14:10], psg4_level[19:15],
	// dma_a_sample[27:20], dma_b_sample[35:28], zero pad [39:36]
	input  wire [InBytes-1:0]    s_axis_tdata,
	// result stream
	output logic                 m_axis_tvalid,
	input  wire                  m_axis_tready,
	// left_out[14:0], right_out[29:15], zero pad [31:30]
	output logic [OutBytes-1:0]  m_axis_tdata
);

	logic [2:0] psg_master_left_q;
	logic [2:0] psg_master_right_q;
	logic [7:0] psg_route_q;
	logic [1:0] psg_ratio_code_q;
	logic [1:0] dma_full_mask_q;
	logic [3:0] dma_route_q;
	logic [8:0] bias_level_q;

	logic       cfg_wr;
	reg_idx_t   cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psg_master_left_q  <= '0;
			psg_master_right_q <= '0;
			psg_route_q        <= '0;
			psg_ratio_code_q   <= '0;
			dma_full_mask_q    <= '0;
			dma_route_q        <= '0;
			bias_level_q       <= BiasReset;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PSG_MASTER_LEFT:  psg_master_left_q  <= pwdata[2:0];
				REG_PSG_MASTER_RIGHT: psg_master_right_q <= pwdata[2:0];
				REG_PSG_ROUTE:        psg_route_q        <= pwdata[7:0];
				REG_PSG_RATIO_CODE:   psg_ratio_code_q   <= pwdata[1:0];
				REG_DMA_FULL_MASK:    dma_full_mask_q    <= pwdata[1:0];
				REG_DMA_ROUTE:        dma_route_q        <= pwdata[3:0];
				REG_BIAS_LEVEL:       bias_level_q       <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PSG_MASTER_LEFT:  prdata = {29'd0, psg_master_left_q};
			REG_PSG_MASTER_RIGHT: prdata = {29'd0, psg_master_right_q};
			REG_PSG_ROUTE:        prdata = {24'd0, psg_route_q};
			REG_PSG_RATIO_CODE:   prdata = {30'd0, psg_ratio_code_q};
			REG_DMA_FULL_MASK:    prdata = {30'd0, dma_full_mask_q};
			REG_DMA_ROUTE:        prdata = {28'd0, dma_route_q};
			REG_BIAS_LEVEL:       prdata = {23'd0, bias_level_q};
			default:              prdata = 32'd0;
		endcase
	end

	// pipeline control
	logic   valid_s1;
	item_t  item_s1;
	logic   out_valid_q;
	logic   out_adv;
	logic   in_acc;

	assign out_adv       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= item_t'(s_axis_tdata[InWidth-1:0]);
		end
	end

	side_cfg_t cfg_left;
	side_cfg_t cfg_right;

	assign cfg_left  = '{tone_en: psg_route_q[7:4], dma_en: dma_route_q[3:2],
	                     master: psg_master_left_q, dma_full: dma_full_mask_q,
	                     ratio: psg_ratio_code_q, bias: bias_level_q};
	assign cfg_right = '{tone_en: psg_route_q[3:0], dma_en: dma_route_q[1:0],
	                     master: psg_master_right_q, dma_full: dma_full_mask_q,
	                     ratio: psg_ratio_code_q, bias: bias_level_q};

	logic signed [OutWidth-1:0] left_mix;
	logic signed [OutWidth-1:0] right_mix;
	logic signed [OutWidth-1:0] left_out_q;
	logic signed [OutWidth-1:0] right_out_q;

	ssm_side u_left (
		.item (item_s1),
		.cfg  (cfg_left),
		.mix  (left_mix)
	);

	ssm_side u_right (
		.item (item_s1),
		.cfg  (cfg_right),
		.mix  (right_mix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			left_out_q  <= left_mix;
			right_out_q <= right_mix;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, right_out_q, left_out_q};

	// an item in stage 1 moves into the output register when it is free
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_adv |=> m_axis_tvalid)
		else $error("stage 1 item lost on its way to the output register");

	// input stalls only when both stages hold an item and the result is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a full pipeline");

	// results are multiples of 32
	a_out_scale: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[4:0] == 5'd0 && m_axis_tdata[19:15] == 5'd0)
		else $error("result not a multiple of 32");

endmodule

`default_nettype wire

// ===== sv/ssm_side.sv =====
// Mix of one output side: tone sum, amplifier, ratio shift, DMA, bias, clamp.
// Purely combinational; depends on ssm_pkg.
`default_nettype none

module ssm_side
	import ssm_pkg::*;
(
	input  wire item_t                   item,
	input  wire side_cfg_t               cfg,
	output logic signed [OutWidth-1:0]   mix
);

	logic signed [6:0]  tone_sum;
	logic signed [10:0] sum_x;
	logic signed [10:0] amp_x;
	logic signed [10:0] tone_prod;
	logic signed [10:0] tone_scaled;
	logic [3:0]         amp;
	logic signed [12:0] dma_a_term;
	logic signed [12:0] dma_b_term;
	logic signed [12:0] bias_term;
	logic signed [12:0] total;
	logic [9:0]         clamped;

	always_comb begin
		tone_sum = 7'sd0;
		if (cfg.tone_en[0]) tone_sum = tone_sum + 7'(item.psg1_level);
		if (cfg.tone_en[1]) tone_sum = tone_sum + 7'(item.psg2_level);
		if (cfg.tone_en[2]) tone_sum = tone_sum + 7'(item.psg3_level);
		if (cfg.tone_en[3]) tone_sum = tone_sum + 7'(item.psg4_level);

		amp         = {1'b0, cfg.master} + 4'd1;
		sum_x       = 11'(tone_sum);
		amp_x       = $signed({7'd0, amp});
		tone_prod   = sum_x * amp_x;
		// arithmetic shift floors, as required for negative sums
		tone_scaled = tone_prod >>> ratio_shift(cfg.ratio);

		dma_a_term = 13'sd0;
		if (cfg.dma_en[0]) begin
			dma_a_term = cfg.dma_full[0] ? $signed({{3{item.dma_a_sample[7]}}, item.dma_a_sample, 2'b00})
			                             : $signed({{4{item.dma_a_sample[7]}}, item.dma_a_sample, 1'b0});
		end
		dma_b_term = 13'sd0;
		if (cfg.dma_en[1]) begin
			dma_b_term = cfg.dma_full[1] ? $signed({{3{item.dma_b_sample[7]}}, item.dma_b_sample, 2'b00})
			                             : $signed({{4{item.dma_b_sample[7]}}, item.dma_b_sample, 1'b0});
		end
		bias_term = $signed({3'd0, cfg.bias, 1'b0});

		total = 13'(tone_scaled) + dma_a_term + dma_b_term + bias_term;

		if (total < 13'sd0)
			clamped = 10'd0;
		else if (total > 13'sd1023)
			clamped = 10'h3FF;
		else
			clamped = total[9:0];

		// (c - 512) * 32: flip the top bit, append five zeros
		mix = $signed({~clamped[9], clamped[8:0], 5'b00000});
	end

endmodule

`default_nettype wire
